FILE: src/waypoint_path_densifier_macros.svh
// ---------------------------------------------------------------------------
// Waypoint path densifier assertion macros
// Short forms for the concurrent checks of the densifier.
// ---------------------------------------------------------------------------
`ifndef WAYPOINT_PATH_DENSIFIER_MACROS_SVH
`define WAYPOINT_PATH_DENSIFIER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define WPD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/wpd_pkg.sv
// ---------------------------------------------------------------------------
// Waypoint path densifier package
// Shared widths, defaults and controller/datapath command types.
// ---------------------------------------------------------------------------
package wpd_pkg;

  localparam int unsigned CW            = 32;
  localparam int unsigned MAX_SEG_DEF   = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIV_STEPS     = CW + 1;
  localparam int unsigned CNT_W         = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    MUL_RES = 2'd0,
    MUL_X   = 2'd1,
    MUL_Y   = 2'd2,
    MUL_Z   = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     search_init;
    logic     search_step;
    logic     div_step;
    logic     emit_first;
    logic     emit_pt;
    logic     commit;
  } wpd_cmd_t;

  typedef struct packed {
    logic found;
    logic at_max;
    logic last_pt;
    logic rem_ok;
  } wpd_stat_t;

endpackage

FILE: src/wpd_ifs.sv
// ---------------------------------------------------------------------------
// Waypoint path densifier channels
// Valid/ready channels for waypoints, path points and the resolution write.
// ---------------------------------------------------------------------------
interface wpd_in_if import wpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] coord_x;
  logic signed [CW-1:0] coord_y;
  logic signed [CW-1:0] coord_z;
  logic                 path_start;

  modport source (output valid, coord_x, coord_y, coord_z, path_start, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, path_start, output ready);
endinterface

interface wpd_out_if import wpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  logic                 run_end;
  logic                 count_clipped;

  modport source (output valid, point_x, point_y, point_z, run_end, count_clipped,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, run_end, count_clipped,
                  output ready);
endinterface

interface wpd_cfg_if import wpd_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/waypoint_path_densifier.sv
// A path's first waypoint is emitted unchanged from S_FIRST once the output is free.
// A later waypoint is squared (resolution, then x, y and z deltas) in S_MUL, set up in
// S_SINIT, searched over counts 1 to 64 in S_SEARCH (one multiple of the resolution a
// cycle) and divided bit-serially in S_DIV, then emits n-1 words at one a cycle while
// the output is not stalled; the next waypoint is taken after the last.
// Reset: asynchronous, active low; clears the stored waypoint, resolution 1.0.
// ---------------------------------------------------------------------------
// Waypoint path densifier
// Streams 3D Q16.16 waypoints and emits evenly spaced straight-line points.
// ---------------------------------------------------------------------------
`include "waypoint_path_densifier_macros.svh"

module waypoint_path_densifier import wpd_pkg::*; #(
  parameter int unsigned MaxSeg   = MAX_SEG_DEF,
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpd_in_if.sink      wp_i,
  wpd_out_if.source   pt_o,
  wpd_cfg_if.sink     cfg_i
);

  wpd_cmd_t  cmd;
  wpd_stat_t st;
  logic      in_ready;
  logic      out_valid;

  // Resolution writes are always taken, so the host must write only while idle.
  assign cfg_i.ready = 1'b1;
  assign wp_i.ready  = in_ready;
  assign pt_o.valid  = out_valid;

  // Controller: one-hot sequencer, owns handshakes and the stored-point flag.
  wpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wp_i.valid),
    .in_start_i  (wp_i.path_start),
    .in_ready_o  (in_ready),
    .out_ready_i (pt_o.ready),
    .out_valid_o (out_valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Datapath: deltas, squared length, count search, divide and stepping.
  wpd_dpath #(
    .MaxSeg   (MaxSeg),
    .FracBits (FracBits)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .in_x_i     (wp_i.coord_x),
    .in_y_i     (wp_i.coord_y),
    .in_z_i     (wp_i.coord_z),
    .cmd_i      (cmd),
    .st_o       (st),
    .pt_x_o     (pt_o.point_x),
    .pt_y_o     (pt_o.point_y),
    .pt_z_o     (pt_o.point_z),
    .run_end_o  (pt_o.run_end),
    .clip_o     (pt_o.count_clipped)
  );

  // Drop ready in the cycle after taking a waypoint.
  `WPD_ASSERT(a_one_at_a_time, (wp_i.valid && wp_i.ready) |=> !wp_i.ready, "busy lost")
  // Hold input while a segment still has points to deliver.
  `WPD_NEVER(a_no_take_mid_run, pt_o.valid && !pt_o.run_end && wp_i.ready, "early take")
  // Keep each stepping remainder below the divisor.
  `WPD_ASSERT(a_rem_bound, cmd.emit_pt |-> st.rem_ok, "remainder overflow")

endmodule

FILE: src/wpd_ctrl.sv
// ---------------------------------------------------------------------------
// Waypoint path densifier controller
// Sequences load, squaring, count search, division and point emission.
// ---------------------------------------------------------------------------
module wpd_ctrl import wpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_start_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  wpd_stat_t st_i,
  output wpd_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FIRST  = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_SINIT  = 7'b0001000,
    S_SEARCH = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               have_prev_q, have_prev_d;
  logic               out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    have_prev_d = have_prev_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_RES;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = (in_start_i || !have_prev_q) ? S_FIRST : S_MUL;
        end
      end
      S_FIRST: begin
        if (out_free) begin
          cmd_o.emit_first = 1'b1;
          cmd_o.commit     = 1'b1;
          have_prev_d      = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mul_sel_e'(cnt_q[1:0]);
        cnt_d         = cnt_q + 1'b1;
        if (mul_sel_e'(cnt_q[1:0]) == MUL_Z) begin
          state_d = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd_o.search_init = 1'b1;
        state_d           = S_SEARCH;
      end
      S_SEARCH: begin
        cmd_o.search_step = 1'b1;
        cnt_d             = '0;
        if (st_i.found || st_i.at_max) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit_pt = 1'b1;
          out_valid_d   = 1'b1;
          if (st_i.last_pt) begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

FILE: src/wpd_dpath.sv
// ---------------------------------------------------------------------------
// Waypoint path densifier datapath
// Deltas, shared squarer, count search, per-axis bit-serial divide, stepping.
// ---------------------------------------------------------------------------
module wpd_dpath import wpd_pkg::*; #(
  parameter int unsigned MaxSeg   = MAX_SEG_DEF,
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CW-1:0]        cfg_data_i,
  input  logic signed [CW-1:0] in_x_i,
  input  logic signed [CW-1:0] in_y_i,
  input  logic signed [CW-1:0] in_z_i,
  input  wpd_cmd_t             cmd_i,
  output wpd_stat_t            st_o,
  output logic signed [CW-1:0] pt_x_o,
  output logic signed [CW-1:0] pt_y_o,
  output logic signed [CW-1:0] pt_z_o,
  output logic                 run_end_o,
  output logic                 clip_o
);

  localparam int unsigned MW    = $clog2(MaxSeg + 1);
  localparam int unsigned DivW  = $clog2(MaxSeg);
  localparam int unsigned AW    = CW + 1;
  localparam int unsigned PW    = 2 * AW;
  localparam int unsigned SW    = 2 * CW + 3;
  localparam int unsigned SqW   = 2 * (CW + MW);
  localparam longint unsigned ResOne = 64'd1 << FracBits;
  localparam longint unsigned ResMin = ResOne / 64'd1000000;

  logic [CW-1:0]        res_q, res_eff;
  logic signed [CW-1:0] p0_q [3];
  logic signed [CW-1:0] p1_q [3];
  logic signed [CW-1:0] in_v [3];
  logic [AW-1:0]        a_q  [3];
  logic                 neg_q [3];
  logic [2*CW-1:0]      rsq_q;
  logic [SW-1:0]        ssq_q;
  logic [AW-1:0]        mul_op;
  logic [PW-1:0]        prod;
  logic [MW-1:0]        m_q;
  logic [SqW-1:0]       sq_q, inc_q, rsq2;
  logic [DivW-1:0]      div_q, k_q;
  logic                 clip_q;
  logic [MW-1:0]        n_sel, n_fix;
  logic [DivW-1:0]      rem_q [3];
  logic [DivW-1:0]      racc_q [3];
  logic [AW-1:0]        qacc_q [3];
  logic [DivW:0]        dv_t  [3];
  logic [DivW:0]        rs    [3];
  logic                 ge    [3];
  logic [DivW-1:0]      rn    [3];
  logic [AW-1:0]        qn    [3];
  logic [AW-1:0]        pn    [3];
  logic                 dbit  [3];
  logic [DivW-1:0]      dv_r  [3];
  logic                 rem_ok;

  assign in_v[0] = in_x_i;
  assign in_v[1] = in_y_i;
  assign in_v[2] = in_z_i;

  // Tiny resolutions fall back to one unit.
  assign res_eff = (64'(res_q) <= ResMin) ? CW'(ResOne) : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= CW'(ResOne);
    end else if (cfg_we_i) begin
      res_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) p0_q[i] <= '0;
    end else if (cmd_i.commit) begin
      for (int i = 0; i < 3; i++) p0_q[i] <= p1_q[i];
    end
  end

  // Shared squarer.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_RES: mul_op = {1'b0, res_eff};
      MUL_X:   mul_op = a_q[0];
      MUL_Y:   mul_op = a_q[1];
      MUL_Z:   mul_op = a_q[2];
      default: mul_op = '0;
    endcase
  end
  assign prod = mul_op * mul_op;

  assign rsq2  = SqW'(rsq_q) << 1;
  assign n_sel = st_o.found ? m_q : MW'(MaxSeg);
  assign n_fix = (n_sel < MW'(2)) ? MW'(2) : n_sel;

  assign st_o.found   = sq_q >= SqW'(ssq_q);
  assign st_o.at_max  = m_q == MW'(MaxSeg);
  assign st_o.last_pt = k_q == div_q;
  assign st_o.rem_ok  = rem_ok;

  always_comb begin
    rem_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      dv_t[i] = {rem_q[i], a_q[i][AW-1]};
      dbit[i] = dv_t[i] >= {1'b0, div_q};
      dv_r[i] = dbit[i] ? DivW'(dv_t[i] - {1'b0, div_q}) : dv_t[i][DivW-1:0];
      rs[i]   = {1'b0, racc_q[i]} + {1'b0, rem_q[i]};
      ge[i]   = rs[i] >= {1'b0, div_q};
      rn[i]   = ge[i] ? DivW'(rs[i] - {1'b0, div_q}) : rs[i][DivW-1:0];
      qn[i]   = qacc_q[i] + a_q[i] + AW'(ge[i]);
      pn[i]   = {p0_q[i][CW-1], p0_q[i]} + (neg_q[i] ? (~qn[i] + 1'b1) : qn[i]);
      if (racc_q[i] >= div_q) rem_ok = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        p1_q[i]  <= in_v[i];
        neg_q[i] <= ({in_v[i][CW-1], in_v[i]} - {p0_q[i][CW-1], p0_q[i]}) >> CW != '0;
        a_q[i]   <= (in_v[i] < p0_q[i]) ?
                    AW'({p0_q[i][CW-1], p0_q[i]} - {in_v[i][CW-1], in_v[i]}) :
                    AW'({in_v[i][CW-1], in_v[i]} - {p0_q[i][CW-1], p0_q[i]});
      end
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MUL_RES: rsq_q <= prod[2*CW-1:0];
        MUL_X:   ssq_q <= SW'(prod);
        MUL_Y,
        MUL_Z:   ssq_q <= ssq_q + SW'(prod);
        default: ssq_q <= ssq_q;
      endcase
    end
    if (cmd_i.search_init) begin
      m_q   <= MW'(1);
      sq_q  <= SqW'(rsq_q);
      inc_q <= SqW'(rsq_q) + rsq2;
    end
    if (cmd_i.search_step) begin
      if (st_o.found || st_o.at_max) begin
        div_q  <= DivW'(n_fix - MW'(1));
        clip_q <= !st_o.found;
        k_q    <= DivW'(1);
        for (int i = 0; i < 3; i++) begin
          rem_q[i]  <= '0;
          racc_q[i] <= '0;
          qacc_q[i] <= '0;
        end
      end else begin
        m_q   <= m_q + 1'b1;
        sq_q  <= sq_q + inc_q;
        inc_q <= inc_q + rsq2;
      end
    end
    // Restoring divide: a becomes the quotient, rem the remainder.
    if (cmd_i.div_step) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= dv_r[i];
        a_q[i]   <= {a_q[i][AW-2:0], dbit[i]};
      end
    end
    if (cmd_i.emit_pt) begin
      for (int i = 0; i < 3; i++) begin
        racc_q[i] <= rn[i];
        qacc_q[i] <= qn[i];
      end
      k_q       <= k_q + 1'b1;
      pt_x_o    <= pn[0][CW-1:0];
      pt_y_o    <= pn[1][CW-1:0];
      pt_z_o    <= pn[2][CW-1:0];
      run_end_o <= st_o.last_pt;
      clip_o    <= clip_q;
    end
    if (cmd_i.emit_first) begin
      pt_x_o    <= p1_q[0];
      pt_y_o    <= p1_q[1];
      pt_z_o    <= p1_q[2];
      run_end_o <= 1'b1;
      clip_o    <= 1'b0;
    end
  end

endmodule
